// ===== hdl/sps_pkg.sv =====
`timescale 1ns / 1ps

package sps_pkg;

    localparam int OP_W      = 2;
    localparam int TIMER_W   = 16;
    localparam int COUNT_W   = 32;
    localparam int SPEED_W   = 24;
    localparam int FREQ_W    = 32;
    localparam int SPT_W     = 16;
    localparam int COIL_W    = 4;
    localparam int PHASE_W   = 3;
    localparam int PERIOD_W  = 16;
    localparam int FRAC_W    = 8;
    localparam int NUM_W     = FREQ_W + FRAC_W;
    localparam int PROD_W    = SPEED_W + SPT_W;
    localparam int MUL_CNT_W = $clog2(SPT_W);
    localparam int DIV_CNT_W = $clog2(PERIOD_W);
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 8;

    localparam logic [FREQ_W-1:0]  FREQ_RESET = FREQ_W'(1000000);
    localparam logic [SPT_W-1:0]   SPT_RESET  = SPT_W'(200);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(7);

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_START_CW  = 2'd1,
        OP_START_CCW = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_FREQ     = 8'd0,
        CFG_STEPS_PER_TURN = 8'd1
    } cfg_idx_t;

    localparam logic [COIL_W-1:0] COIL_AB  = 4'h5;
    localparam logic [COIL_W-1:0] COIL_BA2 = 4'hC;
    localparam logic [COIL_W-1:0] COIL_AB2 = 4'hA;
    localparam logic [COIL_W-1:0] COIL_BA  = 4'h3;
    localparam logic [COIL_W-1:0] COIL_OFF = 4'h0;

    // full-step pattern, each held for two phases
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        unique case (ph[PHASE_W-1:1])
            2'd0:    pat = COIL_AB;
            2'd1:    pat = COIL_BA2;
            2'd2:    pat = COIL_AB2;
            default: pat = COIL_BA;
        endcase
        return pat;
    endfunction

endpackage

// ===== hdl/sps_mul.sv =====
`timescale 1ns / 1ps

module sps_mul import sps_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SPEED_W-1:0]  mcand,
    input  logic [SPT_W-1:0]    mplr,
    output logic                done,
    output logic [PROD_W-1:0]   prod
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    mcand_reg;
    logic [SPT_W-1:0]     mplr_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;

    // one multiplier bit per cycle, lsb first
    assign acc_next = mplr_reg[0] ? acc_reg + mcand_reg : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= MUL_CNT_W'(SPT_W - 1);
                mcand_reg <= PROD_W'(mcand);
                mplr_reg  <= mplr;
                acc_reg   <= '0;
            end else if (busy_reg) begin
                acc_reg   <= acc_next;
                mcand_reg <= {mcand_reg[PROD_W-2:0], 1'b0};
                mplr_reg  <= {1'b0, mplr_reg[SPT_W-1:1]};
                cnt_reg   <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hdl/sps_div.sv =====
`timescale 1ns / 1ps

module sps_div import sps_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [PROD_W-1:0]   den,
    output logic                done,
    output logic [PERIOD_W-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 sat_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    den_reg;
    logic [PERIOD_W-1:0]  lo_reg;
    logic [PERIOD_W-1:0]  quo_reg;
    logic [PROD_W-1:0]    head;
    logic [PROD_W:0]      trial;
    logic [PROD_W:0]      diff;
    logic                 fits;

    // high part of the dividend; quotient overflows when it already covers den
    assign head  = PROD_W'(num[NUM_W-1:PERIOD_W]);
    assign trial = {rem_reg, lo_reg[PERIOD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PERIOD_W - 1);
                rem_reg  <= head;
                den_reg  <= den;
                lo_reg   <= num[PERIOD_W-1:0];
                quo_reg  <= '0;
                sat_reg  <= head >= den;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
                lo_reg  <= {lo_reg[PERIOD_W-2:0], 1'b0};
                quo_reg <= {quo_reg[PERIOD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? '1 : quo_reg;

endmodule

// ===== hdl/stepper_phase_sequencer.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake          payload
// s_       in         s_tvalid/s_tready  s_tuser operation, s_tdata timer/count/speed
// m_       out        m_tvalid/m_tready  m_tdata coils, stepped, busy_res
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
// a tick is answered in the cycle after its transfer when the output register is free
// a start runs the shift-add multiplier for speed * steps_per_turn, hands off to the
// shift-subtract divider for the period, then passes its result to the output register
// s_tready stays low from a start transfer until its result is loaded
// aresetn is synchronous; a stalled m_ side parks the next result in the pending slot
// and keeps s_tready low until the output register drains

module stepper_phase_sequencer import sps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // timer_value, step_count, speed
    input  logic [OP_W-1:0]      s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // coils, stepped, busy_res, zero pad
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_PUSH} state_t;

    state_t               state_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic [SPT_W-1:0]     spt_reg;
    logic [COUNT_W-1:0]   remaining_reg;
    logic                 ccw_reg;
    logic [TIMER_W-1:0]   last_reg;
    logic [PERIOD_W-1:0]  period_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [COIL_W-1:0]    coils_reg;
    logic [M_DATA_W-1:0]  pend_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic [TIMER_W-1:0]   in_timer;
    logic [COUNT_W-1:0]   in_count;
    logic [SPEED_W-1:0]   in_speed;
    op_t                  in_op;
    logic                 accept;
    logic                 out_free;
    logic                 is_start;
    logic                 load_out;
    logic [TIMER_W-1:0]   elapsed;
    logic                 fire;
    logic [COUNT_W-1:0]   remaining_next;
    logic [TIMER_W-1:0]   last_next;
    logic [PHASE_W-1:0]   phase_next;
    logic [COIL_W-1:0]    coils_next;
    logic [M_DATA_W-1:0]  res_next;

    logic                 mul_start;
    logic                 mul_done;
    logic [PROD_W-1:0]    mul_prod;
    logic                 div_start;
    logic                 div_done;
    logic [PERIOD_W-1:0]  div_quot;

    assign in_timer = s_tdata[TIMER_W-1:0];
    assign in_count = s_tdata[TIMER_W+COUNT_W-1:TIMER_W];
    assign in_speed = s_tdata[TIMER_W+COUNT_W+SPEED_W-1:TIMER_W+COUNT_W];
    assign in_op    = op_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_start  = (in_op == OP_START_CW) || (in_op == OP_START_CCW);
    assign elapsed   = in_timer - last_reg;

    // output register loads straight from a tick or from the pending slot
    assign load_out  = ((state_reg == ST_IDLE) && accept && !is_start && out_free)
                    || ((state_reg == ST_PUSH) && out_free);

    always_comb begin
        remaining_next = remaining_reg;
        last_next      = last_reg;
        phase_next     = phase_reg;
        coils_next     = coils_reg;
        fire           = 1'b0;
        unique case (in_op)
            OP_TICK: begin
                if (remaining_reg != '0) begin
                    if (last_reg == '0) begin
                        last_next = in_timer;
                    end else if (elapsed > period_reg) begin
                        fire           = 1'b1;
                        last_next      = in_timer;
                        coils_next     = coil_pattern(phase_reg);
                        remaining_next = remaining_reg - 1'b1;
                        if (ccw_reg) begin
                            phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                        end else begin
                            phase_next = (phase_reg == '0) ? PHASE_LAST : phase_reg - 1'b1;
                        end
                    end
                end else begin
                    coils_next = COIL_OFF;
                end
            end
            OP_START_CW, OP_START_CCW: begin
                remaining_next = in_count;
                last_next      = '0;
            end
            default: begin
            end
        endcase
        res_next = M_DATA_W'({(remaining_next != '0), fire, coils_next});
    end

    assign mul_start = accept && is_start;
    assign div_start = (state_reg == ST_MUL) && mul_done;

    sps_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (in_speed),
        .mplr    (spt_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    sps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({freq_reg, {FRAC_W{1'b0}}}),
        .den     (mul_prod),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            freq_reg      <= FREQ_RESET;
            spt_reg       <= SPT_RESET;
            remaining_reg <= '0;
            ccw_reg       <= 1'b0;
            last_reg      <= '0;
            period_reg    <= '0;
            phase_reg     <= '0;
            coils_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TIMER_FREQ) begin
                    freq_reg <= cfg_data;
                end else if (cfg_index == CFG_STEPS_PER_TURN) begin
                    spt_reg <= cfg_data[SPT_W-1:0];
                end
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        remaining_reg <= remaining_next;
                        last_reg      <= last_next;
                        phase_reg     <= phase_next;
                        coils_reg     <= coils_next;
                        if (is_start) begin
                            ccw_reg   <= (in_op == OP_START_CCW);
                            pend_reg  <= res_next;
                            state_reg <= ST_MUL;
                        end else if (out_free) begin
                            m_tdata_reg  <= res_next;
                        end else begin
                            pend_reg  <= res_next;
                            state_reg <= ST_PUSH;
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        period_reg <= div_quot;
                        state_reg  <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        m_tdata_reg  <= pend_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/sps_checker.sv =====
`timescale 1ns / 1ps

module sps_checker import sps_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [OP_W-1:0]     s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // nothing is offered in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // the period computation keeps the input closed
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_START_CW || s_tuser == OP_START_CCW)
        |=> !s_tready)
        else $error("input open during period computation");

    a_step_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[COIL_W] |-> m_tdata[COIL_W-1:0] != COIL_OFF)
        else $error("step with coils off");

    a_coil_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[COIL_W-1:0] == COIL_OFF || m_tdata[COIL_W-1:0] == COIL_AB
                  || m_tdata[COIL_W-1:0] == COIL_BA2 || m_tdata[COIL_W-1:0] == COIL_AB2
                  || m_tdata[COIL_W-1:0] == COIL_BA)
        else $error("illegal coil pattern");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
